// ----- src/sgd_momentum_update_unit_defines.svh -----
// ----------------------------------------------------------------------------
// sgd momentum update unit assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH
`define SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH

// antecedent implies consequent in the next cycle
`define SGDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgdm assertion failed");

// antecedent implies consequent in the same cycle
`define SGDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgdm assertion failed");

`endif

// ----- src/sgdm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgdm package
// shared widths, register indexes, types and saturation helper
// ----------------------------------------------------------------------------
package sgdm_pkg;

	localparam int unsigned PARAM_COUNT_DEF = 1024;
	localparam int unsigned FRAC_BITS_DEF   = 16;

	localparam int unsigned IDX_W     = 10;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned REG_IDX_W = 4;

	localparam logic [REG_IDX_W-1:0] REG_LR            = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_RATE_DECAY    = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_DECAY  = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_MOMENTUM      = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_DAMPENING     = 4'd4;
	localparam logic [REG_IDX_W-1:0] REG_NESTEROV      = 4'd5;
	localparam logic [REG_IDX_W-1:0] REG_ELEM_DECAY    = 4'd6;
	localparam logic [REG_IDX_W-1:0] REG_ELEM_RATE     = 4'd7;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef struct packed {
		logic [CFG_W-1:0] learning_rate;
		logic [CFG_W-1:0] rate_decay;
		logic [CFG_W-1:0] weight_decay;
		logic [CFG_W-1:0] momentum;
		logic [CFG_W-1:0] dampening;
		logic             nesterov_enable;
		logic             use_element_decay;
		logic             use_element_rate;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] g;
		logic [CFG_W-1:0] coef;
		logic [CFG_W-1:0] er;
		logic             last;
	} elem_t;

	typedef struct packed {
		logic  valid;
		elem_t elem;
	} qhead_t;

	typedef struct packed {
		logic step_inc;
		logic reload;
	} rate_ctl_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[VAL_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[VAL_W-1:0];
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/sgdm_ifs.sv -----
// ----------------------------------------------------------------------------
// sgdm channel interfaces
// element stream, result stream and register write channel
// ----------------------------------------------------------------------------
interface sgdm_item_if;
	import sgdm_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] param_index;
	logic signed [VAL_W-1:0] param_value;
	logic signed [VAL_W-1:0] gradient;
	logic [CFG_W-1:0] element_decay;
	logic [CFG_W-1:0] element_rate;
	logic             last_of_step;
	modport source(output valid, param_index, param_value, gradient, element_decay,
		element_rate, last_of_step, input ready);
	modport sink(input valid, param_index, param_value, gradient, element_decay,
		element_rate, last_of_step, output ready);
endinterface

interface sgdm_result_if;
	import sgdm_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] out_index;
	logic signed [VAL_W-1:0] new_value;
	logic             out_last;
	modport source(output valid, out_index, new_value, out_last, input ready);
	modport sink(input valid, out_index, new_value, out_last, output ready);
endinterface

interface sgdm_cfg_if;
	import sgdm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/sgdm_ram.sv -----
// ----------------------------------------------------------------------------
// sgdm ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sgdm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- src/sgdm_front.sv -----
// ----------------------------------------------------------------------------
// sgdm front
// accepts element beats, picks the decay coefficient, maps the velocity
// address and queues the element for the back end
// ----------------------------------------------------------------------------
module sgdm_front #(
	parameter int unsigned PARAM_COUNT = sgdm_pkg::PARAM_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	sgdm_item_if.sink           item,
	input  sgdm_pkg::cfg_t      cfg,
	input  logic                pop,
	output sgdm_pkg::qhead_t    head,
	output logic [((PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1)-1:0] head_addr
);
	import sgdm_pkg::*;

	localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

	elem_t         mem_q  [2];
	logic [AW-1:0] addr_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	elem_t         in_elem;
	logic [AW-1:0] in_addr;

	generate
		if (PARAM_COUNT >= (1 << IDX_W)) begin : g_direct
			assign in_addr = AW'(item.param_index);
		end else begin : g_wrap
			logic [AW-1:0] mod_tbl [1 << IDX_W];
			for (genvar i = 0; i < (1 << IDX_W); i++) begin : g_tbl
				assign mod_tbl[i] = AW'(i % PARAM_COUNT);
			end
			assign in_addr = mod_tbl[item.param_index];
		end
	endgenerate

	always_comb begin
		in_elem.idx  = item.param_index;
		in_elem.x    = item.param_value;
		in_elem.g    = item.gradient;
		in_elem.er   = item.element_rate;
		in_elem.last = item.last_of_step;
		if (cfg.weight_decay != '0) begin
			in_elem.coef = cfg.weight_decay;
		end else if (cfg.use_element_decay) begin
			in_elem.coef = item.element_decay;
		end else begin
			in_elem.coef = '0;
		end
	end

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.elem  = mem_q[rp_q];
	assign head_addr  = addr_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q]  <= in_elem;
			addr_q[wp_q] <= in_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- src/sgdm_rate.sv -----
// ----------------------------------------------------------------------------
// sgdm rate
// step counter and annealed step size, rate / (1 + steps * decay),
// by restoring division one quotient bit per cycle
// ----------------------------------------------------------------------------
module sgdm_rate #(
	parameter int unsigned FRAC_BITS = sgdm_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sgdm_pkg::cfg_t             cfg,
	input  sgdm_pkg::rate_ctl_t        ctl,
	output logic [sgdm_pkg::CFG_W-1:0] rate,
	output logic                       busy
);
	import sgdm_pkg::*;

	localparam int unsigned QB = CFG_W;
	localparam int unsigned DW = 32 + CFG_W + 1;
	localparam int unsigned SW = DW + QB - 1;
	localparam int unsigned CW = $clog2(QB);
	localparam logic [CFG_W-1:0] RATE_RST =
		CFG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	typedef enum logic [3:0] {
		RS_IDLE = 4'b0001,
		RS_MUL  = 4'b0010,
		RS_PREP = 4'b0100,
		RS_DIV  = 4'b1000
	} rstate_t;

	rstate_t           state_q;
	logic [31:0]       step_q;
	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q;
	logic [SW-1:0]     dsh_q;
	logic [QB-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic [CFG_W-1:0]  rate_q;
	logic [DW-2:0]     den_prod;
	logic              fits;

	assign den_prod = (DW-1)'(step_q) * (DW-1)'(cfg.rate_decay);
	assign fits     = SW'(rem_q) >= dsh_q;
	assign rate     = rate_q;
	assign busy     = (state_q != RS_IDLE);

	always_ff @(posedge clk) begin
		unique case (state_q)
			RS_MUL: begin
				den_q <= (DW'(1) << FRAC_BITS) + DW'(den_prod);
			end
			RS_PREP: begin
				rem_q <= (DW'(cfg.learning_rate) << FRAC_BITS) + (den_q >> 1);
				dsh_q <= SW'(den_q) << (QB - 1);
			end
			RS_DIV: begin
				if (fits) begin
					rem_q <= rem_q - DW'(dsh_q);
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[QB-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			rate_q  <= RATE_RST;
		end else begin
			if (ctl.step_inc) begin
				step_q <= step_q + 32'd1;
			end
			if (ctl.step_inc || ctl.reload) begin
				state_q <= RS_MUL;
			end else begin
				unique case (state_q)
					RS_IDLE: begin
					end
					RS_MUL: begin
						state_q <= RS_PREP;
					end
					RS_PREP: begin
						state_q <= RS_DIV;
						cnt_q   <= CW'(QB - 1);
					end
					RS_DIV: begin
						if (cnt_q == '0) begin
							state_q <= RS_IDLE;
							rate_q  <= {quo_q[QB-2:0], fits};
						end else begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
					default: begin
						state_q <= RS_IDLE;
					end
				endcase
			end
		end
	end
endmodule

// ----- src/sgdm_back.sv -----
// ----------------------------------------------------------------------------
// sgdm back
// update pipeline: decay, velocity with forwarding, direction, step size,
// parameter update and output register
// ----------------------------------------------------------------------------
module sgdm_back #(
	parameter int unsigned PARAM_COUNT = sgdm_pkg::PARAM_COUNT_DEF,
	parameter int unsigned FRAC_BITS   = sgdm_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sgdm_pkg::cfg_t             cfg,
	input  sgdm_pkg::qhead_t           head,
	input  logic [((PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1)-1:0] head_addr,
	output logic                       pop,
	input  logic [sgdm_pkg::CFG_W-1:0] rate,
	input  logic                       rate_busy,
	output logic                       step_inc,
	sgdm_result_if.source              result
);
	import sgdm_pkg::*;

	localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned KW = ((F > CFG_W) ? F : CFG_W) + 2;
	localparam int unsigned SW = 35 - F;
	localparam int unsigned PW = VAL_W + CFG_W + 1;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (F - 1);

	function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
		return (p + HALF) >>> F;
	endfunction

	logic adv;
	logic mom_nz;
	logic started_q;
	logic out_valid_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	elem_t e_s1, e_s2, e_s3, e_s4, e_s5, e_s6, e_s7;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3, addr_s4, addr_s5, addr_s6, addr_s7;
	logic st_s1, st_s2, st_s3;
	logic [CFG_W-1:0] rate_s1, rate_s2, rate_s3, rate_s4, rate_s5;

	logic signed [PW-1:0]         pdec, pdec_s1;
	logic signed [VAL_W-1:0]      d_s2, d_s3, d_s4, d_s5;
	logic [VAL_W-1:0]             ram_rdata;
	logic signed [VAL_W-1:0]      vram_s2, vram_s3;
	logic signed [KW-1:0]         keep;
	logic signed [VAL_W+KW-1:0]   m2_s3;
	logic signed [VAL_W-1:0]      vold;
	logic signed [PW-1:0]         m1;
	logic signed [VAL_W-1:0]      vnew;
	logic signed [VAL_W-1:0]      v_s4, v_s5, v_s6, v_s7;
	logic signed [PW-1:0]         nprod, n_s5;
	logic [2*CFG_W-1:0]           sprod, sp_s5;
	logic signed [VAL_W-1:0]      dir, dir_s6;
	logic [SW-1:0]                stepq, stepq_s6;
	logic signed [SW+VAL_W:0]     prod, prod_s7;
	logic signed [VAL_W-1:0]      nv;

	logic [IDX_W-1:0]        out_idx_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_last_q;

	assign adv      = !out_valid_q || result.ready;
	assign pop      = adv && head.valid && !rate_busy;
	assign step_inc = pop && head.elem.last;
	assign mom_nz   = (cfg.momentum != '0);

	assign pdec = $signed({1'b0, head.elem.coef}) * $signed(head.elem.x);
	assign keep = KW'(64'd1 << F) - KW'(cfg.dampening);

	sgdm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(PARAM_COUNT)
	) u_vel_ram (
		.clk  (clk),
		.we   (adv && vld_s4 && mom_nz),
		.waddr(addr_s4),
		.wdata(v_s4),
		.re   (adv),
		.raddr(head_addr),
		.rdata(ram_rdata)
	);

	// newest pending velocity for the same entry wins
	always_comb begin
		priority if (vld_s4 && addr_s4 == addr_s3) begin
			vold = v_s4;
		end else if (vld_s5 && addr_s5 == addr_s3) begin
			vold = v_s5;
		end else if (vld_s6 && addr_s6 == addr_s3) begin
			vold = v_s6;
		end else if (vld_s7 && addr_s7 == addr_s3) begin
			vold = v_s7;
		end else begin
			vold = vram_s3;
		end
	end

	assign m1   = vold * $signed({1'b0, cfg.momentum});
	assign vnew = st_s3 ? sat32(64'(sat32(rnd(64'(m1)))) + 64'(sat32(rnd(64'(m2_s3)))))
		: d_s3;

	assign nprod = v_s4 * $signed({1'b0, cfg.momentum});
	assign sprod = (2*CFG_W)'(rate_s4) * (2*CFG_W)'(e_s4.er);

	always_comb begin
		if (!mom_nz) begin
			dir = d_s5;
		end else if (cfg.nesterov_enable) begin
			dir = sat32(64'(d_s5) + rnd(64'(n_s5)));
		end else begin
			dir = v_s5;
		end
		if (cfg.use_element_rate) begin
			stepq = SW'(rnd($signed(64'(sp_s5))));
		end else begin
			stepq = SW'(rate_s5);
		end
	end

	assign prod = $signed({1'b0, stepq_s6}) * dir_s6;
	assign nv   = sat32(64'($signed(e_s7.x)) - rnd(64'(prod_s7)));

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1    <= head.elem;
			addr_s1 <= head_addr;
			st_s1   <= started_q;
			rate_s1 <= rate;
			pdec_s1 <= pdec;

			e_s2    <= e_s1;
			addr_s2 <= addr_s1;
			st_s2   <= st_s1;
			rate_s2 <= rate_s1;
			d_s2    <= sat32(64'($signed(e_s1.g)) + rnd(64'(pdec_s1)));
			vram_s2 <= ram_rdata;

			e_s3    <= e_s2;
			addr_s3 <= addr_s2;
			st_s3   <= st_s2;
			rate_s3 <= rate_s2;
			d_s3    <= d_s2;
			vram_s3 <= vram_s2;
			m2_s3   <= d_s2 * keep;

			e_s4    <= e_s3;
			addr_s4 <= addr_s3;
			rate_s4 <= rate_s3;
			d_s4    <= d_s3;
			v_s4    <= vnew;

			e_s5    <= e_s4;
			addr_s5 <= addr_s4;
			rate_s5 <= rate_s4;
			d_s5    <= d_s4;
			v_s5    <= v_s4;
			n_s5    <= nprod;
			sp_s5   <= sprod;

			e_s6     <= e_s5;
			addr_s6  <= addr_s5;
			v_s6     <= v_s5;
			dir_s6   <= dir;
			stepq_s6 <= stepq;

			e_s7    <= e_s6;
			addr_s7 <= addr_s6;
			v_s7    <= v_s6;
			prod_s7 <= prod;

			out_idx_q  <= e_s7.idx;
			out_val_q  <= nv;
			out_last_q <= e_s7.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1      <= pop;
				vld_s2      <= vld_s1;
				vld_s3      <= vld_s2;
				vld_s4      <= vld_s3;
				vld_s5      <= vld_s4;
				vld_s6      <= vld_s5;
				vld_s7      <= vld_s6;
				out_valid_q <= vld_s7;
			end
			if (step_inc && mom_nz) begin
				started_q <= 1'b1;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_index = out_idx_q;
	assign result.new_value = out_val_q;
	assign result.out_last  = out_last_q;
endmodule

// ----- src/sgd_momentum_update_unit.sv -----
// ----------------------------------------------------------------------------
// sgd momentum update unit
// sgd parameter update with momentum, nesterov option and weight decay
// ----------------------------------------------------------------------------
// channel  dir  beat                                         handshake
// item     in   index, value, gradient, decay, rate, last    valid/ready
// result   out  index, new value, last                       valid/ready
// cfg      in   register index, write data                   valid/ready
//
// one element per cycle unless the result stalls or the rate divider is busy
// after the last element of a step the step size is recomputed in the rate divider,
// one quotient bit per cycle; no element starts meanwhile
// reset clears control state only; the velocity ram is not cleared
// a stalled result holds the whole update pipeline; the input queue keeps taking
// beats until its two entries are full
// ----------------------------------------------------------------------------
module sgd_momentum_update_unit #(
	parameter int unsigned PARAM_COUNT = sgdm_pkg::PARAM_COUNT_DEF,
	parameter int unsigned FRAC_BITS   = sgdm_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sgdm_item_if.sink     item,
	sgdm_result_if.source result,
	sgdm_cfg_if.sink      cfg
);
	import sgdm_pkg::*;

	localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam logic [CFG_W-1:0] LR_RST =
		CFG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	cfg_t          cfg_q;
	qhead_t        head;
	logic [AW-1:0] head_addr;
	logic          pop;
	logic          step_inc;
	logic [CFG_W-1:0] rate;
	logic          rate_busy;
	rate_ctl_t     rate_ctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{learning_rate: LR_RST, default: '0};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LR:           cfg_q.learning_rate     <= cfg.data;
				REG_RATE_DECAY:   cfg_q.rate_decay        <= cfg.data;
				REG_WEIGHT_DECAY: cfg_q.weight_decay      <= cfg.data;
				REG_MOMENTUM:     cfg_q.momentum          <= cfg.data;
				REG_DAMPENING:    cfg_q.dampening         <= cfg.data;
				REG_NESTEROV:     cfg_q.nesterov_enable   <= cfg.data[0];
				REG_ELEM_DECAY:   cfg_q.use_element_decay <= cfg.data[0];
				REG_ELEM_RATE:    cfg_q.use_element_rate  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign rate_ctl.step_inc = step_inc;
	assign rate_ctl.reload   = cfg.valid &&
		(cfg.index == REG_LR || cfg.index == REG_RATE_DECAY);

	sgdm_front #(
		.PARAM_COUNT(PARAM_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg_q),
		.pop      (pop),
		.head     (head),
		.head_addr(head_addr)
	);

	sgdm_rate #(
		.FRAC_BITS(FRAC_BITS)
	) u_rate (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.ctl   (rate_ctl),
		.rate  (rate),
		.busy  (rate_busy)
	);

	sgdm_back #(
		.PARAM_COUNT(PARAM_COUNT),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.head_addr(head_addr),
		.pop      (pop),
		.rate     (rate),
		.rate_busy(rate_busy),
		.step_inc (step_inc),
		.result   (result)
	);
endmodule

// ----- src/sgdm_checker.sv -----
// ----------------------------------------------------------------------------
// sgdm checker
// port level checks on the result channel and beat accounting
// ----------------------------------------------------------------------------
`include "sgd_momentum_update_unit_defines.svh"

module sgdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [9:0]  res_index,
	input logic [31:0] res_value,
	input logic        res_last
);
	logic [4:0] outst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 5'(item_valid && item_ready) - 5'(res_valid && res_ready);
		end
	end

	`SGDM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`SGDM_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_index) && $stable(res_value) && $stable(res_last))
	`SGDM_ASSERT_NOW(a_res_has_item, clk, arst_n, res_valid, outst_q != 5'd0)
	`SGDM_ASSERT_NOW(a_outst_bound, clk, arst_n, 1'b1, outst_q <= 5'd10)
endmodule

bind sgd_momentum_update_unit sgdm_checker u_sgdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_index (result.out_index),
	.res_value (result.new_value),
	.res_last  (result.out_last)
);
